// ===== design/otp_pkg.sv =====
// ----------------------------------------------------------------------------
// otp_pkg
// shared types and constants of the one-time password engine
// ----------------------------------------------------------------------------
package otp_pkg;

	// control for the sha-1 round unit, one action per cycle
	typedef struct packed {
		logic init;   // load initial chaining value
		logic load;   // copy chain into working variables
		logic step;   // run one round
		logic fin;    // add working variables into chain
	} sha_ctl_t;

	localparam logic [31:0] SHA_IV0 = 32'h6745_2301;
	localparam logic [31:0] SHA_IV1 = 32'hEFCD_AB89;
	localparam logic [31:0] SHA_IV2 = 32'h98BA_DCFE;
	localparam logic [31:0] SHA_IV3 = 32'h1032_5476;
	localparam logic [31:0] SHA_IV4 = 32'hC3D2_E1F0;

	localparam logic [31:0] SHA_K0 = 32'h5A82_7999;
	localparam logic [31:0] SHA_K1 = 32'h6ED9_EBA1;
	localparam logic [31:0] SHA_K2 = 32'h8F1B_BCDC;
	localparam logic [31:0] SHA_K3 = 32'hCA62_C1D6;

	localparam logic [6:0]  LAST_ROUND = 7'd79;

	localparam logic [7:0]  IPAD      = 8'h36;
	localparam logic [7:0]  OPAD      = 8'h5C;
	localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
	localparam logic [31:0] INNER_LEN = 32'd576;   // 72 bytes in bits
	localparam logic [31:0] OUTER_LEN = 32'd672;   // 84 bytes in bits

	localparam logic [19:0] TOTP_STEP = 20'd30;
	localparam logic [19:0] PIN_MOD   = 20'd1000000;
	localparam logic [4:0]  WINDOW    = 5'd30;

	// reciprocals: x / d = (x * magic) >> (32 + shift), exact for any 32-bit x
	localparam logic [31:0] STEP_MAGIC = 32'h8888_8889;
	localparam int          STEP_SHIFT = 4;
	localparam logic [31:0] PIN_MAGIC  = 32'h431B_DE83;
	localparam int          PIN_SHIFT  = 18;

endpackage

// ===== design/otp_sha1_round.sv =====
// ----------------------------------------------------------------------------
// otp_sha1_round
// shared sha-1 round unit with chaining registers and a 16-word schedule line
// ----------------------------------------------------------------------------
module otp_sha1_round (
	input  logic             clk,
	input  logic             arst_n,
	input  otp_pkg::sha_ctl_t ctl,
	input  logic [6:0]       round,
	input  logic [31:0]      w_in,
	output logic [159:0]     chain
);
	import otp_pkg::*;

	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];   // w_q[0] oldest, w_q[15] newest

	logic [31:0] w_x, w_sched, w_cur, f, k, tmp;

	always_comb begin
		w_x     = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_sched = {w_x[30:0], w_x[31]};
		w_cur   = (round < 7'd16) ? w_in : w_sched;
		priority if (round < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = SHA_K0;
		end else if (round < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K1;
		end else if (round < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = SHA_K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) h_q[i] <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
		end else begin
			if (ctl.init) begin
				h_q[0] <= SHA_IV0; h_q[1] <= SHA_IV1; h_q[2] <= SHA_IV2;
				h_q[3] <= SHA_IV3; h_q[4] <= SHA_IV4;
			end
			if (ctl.load) begin
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
				d_q <= h_q[3]; e_q <= h_q[4];
			end
			if (ctl.step) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_cur;
				e_q <= d_q;
				d_q <= c_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q;
				a_q <= tmp;
			end
			if (ctl.fin) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
		end
	end

	assign chain = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

endmodule

// ===== design/otp_div.sv =====
// ----------------------------------------------------------------------------
// otp_div
// reciprocal divider for the two fixed divisors, 30 and the pin modulus
// ----------------------------------------------------------------------------
module otp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [19:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [19:0] remainder
);
	import otp_pkg::*;

	typedef enum logic [1:0] {
		P_IDLE, P_RECIP, P_BACK
	} phase_t;

	phase_t      phase_q;
	logic        done_q;
	logic        big_q;   // dividing by the pin modulus
	logic [31:0] x_q, quo_q;
	logic [19:0] rem_q, dvs_q;

	logic [31:0] mul_a, mul_b, quo_next, diff;
	logic [63:0] prod;

	// one 32x32 multiplier: reciprocal product first, then quotient times divisor
	assign mul_a = (phase_q == P_RECIP) ? x_q : quo_q;
	assign mul_b = (phase_q == P_RECIP) ? (big_q ? PIN_MAGIC : STEP_MAGIC)
		: {12'd0, dvs_q};
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	assign quo_next = big_q ? (prod[63:32] >> PIN_SHIFT) : (prod[63:32] >> STEP_SHIFT);
	assign diff     = x_q - prod[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
			big_q   <= 1'b0;
			x_q     <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			dvs_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (go) begin
						x_q     <= dividend;
						dvs_q   <= divisor;
						big_q   <= (divisor != TOTP_STEP);
						phase_q <= P_RECIP;
					end
				end
				P_RECIP: begin
					quo_q   <= quo_next;
					phase_q <= P_BACK;
				end
				P_BACK: begin
					rem_q   <= diff[19:0];
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/otp_pin_generator_core.sv =====
// ----------------------------------------------------------------------------
// otp_pin_generator_core
// six-digit hotp/totp engine: hmac-sha1 over the moving factor, truncation
// ----------------------------------------------------------------------------
// after acceptance the steps run in order: time / 30 on the reciprocal divider,
//   four sha-1 blocks on the one round unit plus two chain setups, one truncation
//   step, then the modulo on the divider; done pulses once the modulo is through
// a load transaction writes one key byte and gives no result
// a new compute is taken only once the last one is through, busy stays high meanwhile
// reset: asynchronous, key_length returns to 20, key store holds garbage
// the receiver cannot stall: done pulses one cycle with pin and seconds_left
module otp_pin_generator_core #(
	parameter int KEY_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [5:0]  key_index,
	input  logic [7:0]  key_byte,
	input  logic        is_hotp,
	input  logic [63:0] event_counter,
	input  logic [31:0] unix_time,
	// result
	output logic        done,
	output logic [19:0] pin,
	output logic [4:0]  seconds_left,
	// key length register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	import otp_pkg::*;

	localparam int WORDS = (KEY_BYTES + 3) / 4;
	localparam int AW    = $clog2(WORDS);

	typedef enum logic [3:0] {
		S_IDLE, S_TDIV, S_TWAIT, S_INIT, S_LOAD, S_ROUND, S_FIN, S_NEXT,
		S_TRUNC, S_MDIV, S_MWAIT
	} state_t;

	state_t       state_q;
	logic [1:0]   blk_q;         // 0 ipad key, 1 factor, 2 opad key, 3 inner digest
	logic [6:0]   cnt_q;         // round counter
	logic [6:0]   key_len_q;
	logic         hotp_q;
	logic [63:0]  factor_q;
	logic [31:0]  time_q;
	logic [4:0]   secs_q;
	logic [159:0] inner_q;
	logic [31:0]  trunc_q;
	logic [19:0]  pin_q;
	logic         done_q;

	// key store, 32-bit words with byte lanes
	logic [31:0] key_mem [WORDS];
	logic [31:0] key_rd_q;
	logic [AW-1:0] rd_addr;
	logic        key_wr;

	sha_ctl_t     sha_ctl;
	logic [31:0]  w_in;
	logic [159:0] chain;

	logic        div_go, div_done;
	logic [31:0] div_dividend, div_quot;
	logic [19:0] div_divisor, div_rem;

	logic [6:0]  len_eff;
	logic [31:0] key_word;
	logic [7:0]  pad_byte;
	logic [7:0]  trunc_sh;
	logic [31:0] trunc_sel;

	// effective key length saturates at the store size
	assign len_eff = (key_len_q > 7'(KEY_BYTES)) ? 7'(KEY_BYTES) : key_len_q;

	// ---------------- key store ----------------
	assign key_wr = (state_q == S_IDLE) && start && !kind
		&& ({1'b0, key_index} < 7'(KEY_BYTES));

	always_ff @(posedge clk) begin
		if (key_wr)
			key_mem[key_index[AW+1:2]][8*(3-key_index[1:0]) +: 8] <= key_byte;
		key_rd_q <= key_mem[rd_addr];
	end

	// fetch one word ahead of the round that consumes it
	assign rd_addr = (state_q == S_LOAD) ? '0 : AW'(cnt_q + 7'd1);

	// ---------------- block word source ----------------
	assign pad_byte = blk_q[1] ? OPAD : IPAD;

	always_comb begin
		// bytes past the key length read as zero before the pad is applied
		for (int j = 0; j < 4; j++) begin
			if ({1'b0, cnt_q[3:0], 2'(j)} < len_eff)
				key_word[31-8*j -: 8] = key_rd_q[31-8*j -: 8] ^ pad_byte;
			else
				key_word[31-8*j -: 8] = pad_byte;
		end
	end

	always_comb begin
		w_in = '0;
		unique case (blk_q)
			2'd0, 2'd2: w_in = key_word;
			2'd1: begin
				priority case (cnt_q)
					7'd0:    w_in = factor_q[63:32];
					7'd1:    w_in = factor_q[31:0];
					7'd2:    w_in = PAD_WORD;
					7'd15:   w_in = INNER_LEN;
					default: w_in = '0;
				endcase
			end
			2'd3: begin
				priority case (cnt_q)
					7'd0:    w_in = inner_q[159:128];
					7'd1:    w_in = inner_q[127:96];
					7'd2:    w_in = inner_q[95:64];
					7'd3:    w_in = inner_q[63:32];
					7'd4:    w_in = inner_q[31:0];
					7'd5:    w_in = PAD_WORD;
					7'd15:   w_in = OUTER_LEN;
					default: w_in = '0;
				endcase
			end
			default: w_in = '0;
		endcase
	end

	// ---------------- shared units ----------------
	always_comb begin
		sha_ctl.init = (state_q == S_INIT);
		sha_ctl.load = (state_q == S_LOAD);
		sha_ctl.step = (state_q == S_ROUND);
		sha_ctl.fin  = (state_q == S_FIN);
	end

	otp_sha1_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sha_ctl),
		.round  (cnt_q),
		.w_in   (w_in),
		.chain  (chain)
	);

	// one divider serves time / 30 and the final modulo
	assign div_go       = (state_q == S_TDIV) || (state_q == S_MDIV);
	assign div_dividend = (state_q == S_TDIV) ? time_q : trunc_q;
	assign div_divisor  = (state_q == S_TDIV) ? TOTP_STEP : PIN_MOD;

	otp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// dynamic truncation: bytes off..off+3 of the mac, off = low nibble of last byte
	assign trunc_sh  = 8'd128 - {1'b0, chain[3:0], 3'b000};
	assign trunc_sel = 32'(chain >> trunc_sh);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			blk_q     <= '0;
			cnt_q     <= '0;
			key_len_q <= 7'd20;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				key_len_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (start && kind)
						state_q <= S_TDIV;
				end
				S_TDIV:  state_q <= S_TWAIT;
				S_TWAIT: begin
					if (div_done) begin
						blk_q   <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT:  state_q <= S_LOAD;
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == LAST_ROUND)
						state_q <= S_FIN;
				end
				S_FIN:   state_q <= S_NEXT;
				S_NEXT: begin
					blk_q <= blk_q + 2'd1;
					priority case (blk_q)
						2'd1:    state_q <= S_INIT;
						2'd3:    state_q <= S_TRUNC;
						default: state_q <= S_LOAD;
					endcase
				end
				S_TRUNC: state_q <= S_MDIV;
				S_MDIV:  state_q <= S_MWAIT;
				S_MWAIT: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && kind) begin
			hotp_q   <= is_hotp;
			factor_q <= event_counter;
			time_q   <= unix_time;
		end
		if (state_q == S_TWAIT && div_done) begin
			secs_q <= WINDOW - div_rem[4:0];
			if (!hotp_q)
				factor_q <= {32'd0, div_quot};
		end
		if (state_q == S_NEXT && blk_q == 2'd1)
			inner_q <= chain;
		if (state_q == S_TRUNC)
			trunc_q <= {1'b0, trunc_sel[30:0]};
		if (state_q == S_MWAIT && div_done)
			pin_q <= div_rem;
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign done         = done_q;
	assign pin          = pin_q;
	assign seconds_left = secs_q;

	// ---------------- checks ----------------
	a_done_from_mod: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_MWAIT))
		else $error("result strobe without a finished modulo");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result strobed");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> cnt_q <= LAST_ROUND)
		else $error("round counter overran");

	a_pin_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pin < PIN_MOD) && (seconds_left >= 5'd1) && (seconds_left <= WINDOW))
		else $error("result out of range");

endmodule
